>>> src/lgg_pkg.sv
// shared constants and types for the life grid generation step block
`default_nettype none

package lgg_pkg;

   // grid geometry
   localparam int ROWS = 64;
   localparam int COLS = 64;

   // address, column index and step counter widths
   localparam int ROW_AW = $clog2(ROWS);
   localparam int COL_AW = $clog2(COLS);
   localparam int CNT_W  = $clog2(ROWS + 2);

   // step sweep counter marks
   localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_WR0   = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_ROWS  = CNT_W'(ROWS);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(ROWS + 1);

   // operation codes
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // control states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_WR,
      ST_STEP,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> src/lgg_row_rule.sv
// b3/s23 rule applied to one row word given the rows above and below
`default_nettype none

module lgg_row_rule (
   input  wire logic [lgg_pkg::COLS-1:0] above,
   input  wire logic [lgg_pkg::COLS-1:0] here,
   input  wire logic [lgg_pkg::COLS-1:0] below,
   output logic      [lgg_pkg::COLS-1:0] next_row
);
   import lgg_pkg::*;

   logic [COLS+1:0] above_pad;
   logic [COLS+1:0] here_pad;
   logic [COLS+1:0] below_pad;

   // dead cells past both edges
   assign above_pad = {1'b0, above, 1'b0};
   assign here_pad  = {1'b0, here,  1'b0};
   assign below_pad = {1'b0, below, 1'b0};

   // neighbor count and rule, one column at a time
   always_comb begin
      logic [3:0] total;
      next_row = '0;
      for (int c = 0; c < COLS; c++) begin
         total = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
               + 4'(here_pad[c])                       + 4'(here_pad[c+2])
               + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);
         next_row[c] = (total == 4'd3) || (here[c] && (total == 4'd2));
      end
   end

endmodule

`default_nettype wire

>>> src/life_grid_generation_step.sv
// top level: life grid in a row memory with cell access and generation sweep
// read and write pass through a registered row read and the result register; clear goes straight to done
// a generation step sweeps every row once: one row read and one row written per cycle
// throughput: one item at a time; the next item is taken while a result waits
// reset: synchronous, clears control state and all row valid bits (grid all dead)
// no clearing pass: a row with its valid bit low reads as all dead
`default_nettype none

module life_grid_generation_step (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [5:0] req_row,
   input  wire logic [5:0] req_col,
   input  wire logic       req_value,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_cell_res
);
   import lgg_pkg::*;

   state_type state_ff, state_in;

   logic              req_acc;
   op_type            req_op_e;
   logic              req_inside;

   // latched item fields
   logic [ROW_AW-1:0] row_ff;
   logic [COL_AW-1:0] col_ff;
   logic              value_ff;
   logic              inside_ff;
   logic              res_ff, res_in;

   // step sweep
   logic [CNT_W-1:0]  cnt_ff;
   logic [COLS-1:0]   above_ff;
   logic [COLS-1:0]   cur_ff;
   logic [COLS-1:0]   below;
   logic [COLS-1:0]   rule_row;

   // row memory and valid bits
   logic [COLS-1:0]   mem [ROWS];
   logic [COLS-1:0]   mem_q_ff;
   logic              rdv_ff;
   logic [ROWS-1:0]   row_valid_ff;
   logic [COLS-1:0]   rd_row;

   logic              rd_en;
   logic [ROW_AW-1:0] rd_addr;
   logic              wr_en;
   logic [ROW_AW-1:0] wr_addr;
   logic [COLS-1:0]   wr_data;
   logic              clear_en;
   logic              rsp_load;

   logic              rsp_valid_ff;
   logic              rsp_cell_res_ff;

   assign req_op_e   = op_type'(req_op);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign req_inside = (int'(req_row) < ROWS) && (int'(req_col) < COLS);

   // row data from memory, dead when never written since last clear
   assign rd_row = rdv_ff ? mem_q_ff : '0;

   // row below the one being rewritten, dead past the last row
   assign below = (cnt_ff <= CNT_ROWS) ? rd_row : '0;

   lgg_row_rule u_rule (
      .above    (above_ff),
      .here     (cur_ff),
      .below    (below),
      .next_row (rule_row)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_op_e)
                  OP_WRITE: state_in = ST_WR;
                  OP_READ:  state_in = ST_RD;
                  OP_STEP:  state_in = ST_STEP;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_RD:   state_in = ST_DONE;
         ST_WR:   state_in = ST_DONE;
         ST_STEP: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory controls and result
   always_comb begin
      logic [COLS-1:0] mod_row;
      mod_row  = rd_row;
      rd_en    = 1'b0;
      rd_addr  = ROW_AW'(req_row);
      wr_en    = 1'b0;
      wr_addr  = row_ff;
      wr_data  = rule_row;
      clear_en = 1'b0;
      rsp_load = 1'b0;
      res_in   = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               res_in = 1'b0;
               case (req_op_e)
                  OP_WRITE, OP_READ: rd_en = req_inside;
                  OP_STEP: begin
                     rd_en   = 1'b1;
                     rd_addr = '0;
                  end
                  default: clear_en = 1'b1;
               endcase
            end
         end
         ST_RD: begin
            res_in = inside_ff && rd_row[col_ff];
         end
         ST_WR: begin
            mod_row[col_ff] = value_ff;
            wr_en   = inside_ff;
            wr_data = mod_row;
         end
         ST_STEP: begin
            rd_en   = (cnt_ff < CNT_ROWS);
            rd_addr = cnt_ff[ROW_AW-1:0];
            wr_en   = (cnt_ff >= CNT_WR0);
            wr_addr = ROW_AW'(cnt_ff - CNT_WR0);
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_acc) begin
            cnt_ff <= CNT_FIRST;
         end else if (state_ff == ST_STEP) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // row valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (clear_en) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // row memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
         rdv_ff   <= row_valid_ff[rd_addr];
      end
   end

   // item fields, step row window and result beat
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (req_acc) begin
         row_ff    <= ROW_AW'(req_row);
         col_ff    <= COL_AW'(req_col);
         value_ff  <= req_value;
         inside_ff <= req_inside;
      end
      if (state_ff == ST_STEP) begin
         if (cnt_ff == CNT_FIRST) begin
            above_ff <= '0;
            cur_ff   <= rd_row;
         end else begin
            above_ff <= cur_ff;
            cur_ff   <= below;
         end
      end
      if (rsp_load) begin
         rsp_cell_res_ff <= res_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_res = rsp_cell_res_ff;

   // a new result beat comes only out of the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result beat loaded outside done state");

   // sweep counter stays within the step window
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> (cnt_ff >= CNT_FIRST) && (cnt_ff <= CNT_LAST))
      else $error("step counter out of range");

   // a clear leaves every row dead
   assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_op_e == OP_CLEAR) |=> row_valid_ff == '0)
      else $error("clear left live rows");

   // the sweep never reads a row in the cycle it rewrites it
   assert property (@(posedge clock) disable iff (reset)
      wr_en && rd_en |-> wr_addr != rd_addr)
      else $error("read and write of one row in the same cycle");

endmodule

`default_nettype wire

>>> verif/life_grid_generation_step_tb.sv
// testbench for the life grid generation step block: directed table, then random seeded patterns
module life_grid_generation_step_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lgg_pkg::*;

   localparam int TARGET_ITEMS = 1850;
   localparam int LONG_HOLD    = 200;
   localparam int WIN          = 8;

   typedef struct {
      op_type     op;
      logic [5:0] row;
      logic [5:0] col;
      logic       value;
      bit         known;
      logic       known_res;
   } plan_entry_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op    = OP_READ;
   logic [5:0] req_row   = '0;
   logic [5:0] req_col   = '0;
   logic       req_value = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_cell_res;

   // shadow copy of the grid, one word per row, bit c is column c
   logic [COLS-1:0] life_grid [ROWS];
   logic            cell_expect_q [$];
   int              error_count  = 0;
   int              items_sent   = 0;
   bit              sender_calm  = 1'b0;
   bit              receiver_calm = 1'b0;

   // directed table: corners, edge blinker without wrap, clear, empty step
   plan_entry_type directed_plan [25] = '{
      '{OP_READ,  6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
      '{OP_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b0},
      '{OP_WRITE, 6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
      '{OP_READ,  6'd0,  6'd0,  1'b0, 1'b1, 1'b1},
      '{OP_WRITE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
      '{OP_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b1},
      '{OP_WRITE, 6'd0,  6'd63, 1'b1, 1'b1, 1'b0},
      '{OP_WRITE, 6'd63, 6'd0,  1'b1, 1'b1, 1'b0},
      '{OP_READ,  6'd63, 6'd0,  1'b1, 1'b1, 1'b1},
      '{OP_STEP,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
      '{OP_READ,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0},
      '{OP_READ,  6'd0,  6'd63, 1'b0, 1'b1, 1'b0},
      '{OP_WRITE, 6'd0,  6'd61, 1'b1, 1'b0, 1'b0},
      '{OP_WRITE, 6'd0,  6'd62, 1'b1, 1'b0, 1'b0},
      '{OP_WRITE, 6'd0,  6'd63, 1'b1, 1'b0, 1'b0},
      '{OP_STEP,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
      '{OP_READ,  6'd0,  6'd62, 1'b0, 1'b0, 1'b0},
      '{OP_READ,  6'd1,  6'd62, 1'b0, 1'b0, 1'b0},
      '{OP_READ,  6'd63, 6'd62, 1'b1, 1'b0, 1'b0},
      '{OP_WRITE, 6'd1,  6'd62, 1'b0, 1'b0, 1'b0},
      '{OP_READ,  6'd1,  6'd62, 1'b0, 1'b1, 1'b0},
      '{OP_CLEAR, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
      '{OP_READ,  6'd0,  6'd62, 1'b0, 1'b1, 1'b0},
      '{OP_STEP,  6'd21, 6'd42, 1'b1, 1'b1, 1'b0},
      '{OP_READ,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0}
   };

   life_grid_generation_step i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_cell_res (rsp_cell_res)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // next generation of one row from the old rows above, here and below
   function automatic logic [COLS-1:0] evolve_row(input logic [COLS-1:0] above,
                                                  input logic [COLS-1:0] here,
                                                  input logic [COLS-1:0] below);
      logic [COLS-1:0] next_gen;
      int              neighbors;
      next_gen = '0;
      for (int c = 0; c < COLS; c++) begin
         neighbors = 0;
         for (int d = -1; d <= 1; d++) begin
            if (c + d >= 0 && c + d < COLS) begin
               neighbors += int'(above[c + d]) + int'(below[c + d]);
               if (d != 0) neighbors += int'(here[c + d]);
            end
         end
         next_gen[c] = (neighbors == 3) || (here[c] && neighbors == 2);
      end
      return next_gen;
   endfunction

   // whole-grid step, all counts taken from the old generation
   function automatic void advance_grid();
      logic [COLS-1:0] old_gen [ROWS];
      logic [COLS-1:0] above;
      logic [COLS-1:0] below;
      old_gen = life_grid;
      for (int r = 0; r < ROWS; r++) begin
         above = '0;
         below = '0;
         if (r > 0) above = old_gen[r - 1];
         if (r < ROWS - 1) below = old_gen[r + 1];
         life_grid[r] = evolve_row(above, old_gen[r], below);
      end
   endfunction

   // apply one accepted beat to the shadow grid and return the expected cell
   function automatic logic apply_grid_op(input op_type op, input logic [5:0] row,
                                          input logic [5:0] col, input logic value);
      logic read_bit;
      bit   on_grid;
      read_bit = 1'b0;
      on_grid  = (int'(row) < ROWS) && (int'(col) < COLS);
      case (op)
         OP_WRITE: if (on_grid) life_grid[row][col] = value;
         OP_READ:  if (on_grid) read_bit = life_grid[row][col];
         OP_STEP:  advance_grid();
         default: begin
            foreach (life_grid[r]) life_grid[r] = '0;
         end
      endcase
      return read_bit;
   endfunction

   // present one beat after a random gap and hold it until taken
   task automatic offer_item(input op_type op, input logic [5:0] row, input logic [5:0] col,
                             input logic value, input bit known, input logic known_res);
      int   gap;
      logic predicted;
      if ($urandom_range(0, 31) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_row   <= row;
      req_col   <= col;
      req_value <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = apply_grid_op(op, row, col, value);
      cell_expect_q.push_back(known ? known_res : predicted);
      items_sent++;
   endtask

   task automatic offer_noise();
      offer_item(op_type'($urandom_range(0, 3)), 6'($urandom), 6'($urandom), 1'($urandom),
                 1'b0, 1'b0);
   endtask

   // stimulus
   initial begin
      int base_row;
      int base_col;
      int count;
      foreach (life_grid[r]) life_grid[r] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         offer_item(directed_plan[i].op, directed_plan[i].row, directed_plan[i].col,
                    directed_plan[i].value, directed_plan[i].known, directed_plan[i].known_res);
      end

      // random episodes: seed a window, run a few generations, probe around it
      while (items_sent < TARGET_ITEMS) begin
         if ($urandom_range(0, 3) != 0)
            offer_item(OP_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom), 1'b0, 1'b0);
         case ($urandom_range(0, 3))
            0:       base_row = 0;
            1:       base_row = ROWS - WIN;
            default: base_row = $urandom_range(0, ROWS - WIN);
         endcase
         case ($urandom_range(0, 3))
            0:       base_col = 0;
            1:       base_col = COLS - WIN;
            default: base_col = $urandom_range(0, COLS - WIN);
         endcase
         count = $urandom_range(8, 30);
         repeat (count) begin
            offer_item(OP_WRITE, 6'(base_row + $urandom_range(0, WIN - 1)),
                       6'(base_col + $urandom_range(0, WIN - 1)),
                       1'($urandom_range(0, 3) != 0), 1'b0, 1'b0);
         end
         repeat ($urandom_range(1, 3)) begin
            offer_item(OP_STEP, 6'($urandom), 6'($urandom), 1'($urandom), 1'b0, 1'b0);
            count = $urandom_range(4, 12);
            repeat (count) begin
               offer_item(OP_READ, 6'(base_row + $urandom_range(0, WIN - 1)),
                          6'(base_col + $urandom_range(0, WIN - 1)), 1'($urandom),
                          1'b0, 1'b0);
            end
            offer_item(OP_READ, 6'($urandom), 6'($urandom), 1'($urandom), 1'b0, 1'b0);
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) offer_noise();
         end
      end
      req_valid <= 1'b0;

      // drain, then allow for a late spurious beat
      while (cell_expect_q.size() != 0) @(posedge clock);
      repeat (ROWS + 8) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // result side stall pattern, with two long hold-offs to back up the input
   initial begin
      int hold;
      int rsp_seen;
      rsp_seen = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) receiver_calm = !receiver_calm;
         if (rsp_seen == 120 || rsp_seen == 1000)
            hold = LONG_HOLD;
         else
            hold = receiver_calm ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         rsp_seen++;
      end
   end

   // compare each result beat with the oldest expected cell
   always @(posedge clock) begin
      logic expected_cell;
      if (reset == 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (cell_expect_q.size() == 0) begin
            $display("%0t ns: unexpected result beat, expected none, actual cell_res %b",
                     $time, rsp_cell_res);
            error_count++;
         end else begin
            expected_cell = cell_expect_q.pop_front();
            if (rsp_cell_res !== expected_cell) begin
               $display("%0t ns: cell_res mismatch, expected %b, actual %b",
                        $time, expected_cell, rsp_cell_res);
               error_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #10ms;
      $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
src/lgg_pkg.sv
src/lgg_row_rule.sv
src/life_grid_generation_step.sv
verif/life_grid_generation_step_tb.sv
